// ----- rtl/i2c_master_irq_transfer_sequencer_unit_assert.svh -----
// ----------------------------------------------------------------------------
// I2C master IRQ sequencer assertion macros
// Concurrent checks, compiled out for synthesis.
// ----------------------------------------------------------------------------
`ifndef I2C_MASTER_IRQ_TRANSFER_SEQUENCER_UNIT_ASSERT_SVH
`define I2C_MASTER_IRQ_TRANSFER_SEQUENCER_UNIT_ASSERT_SVH
`ifndef SYNTHESIS
`define I2CMIS_ASSERT(lbl, clk, rstn, prop) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) prop) \
    else $error("i2cmis assertion failed");
`define I2CMIS_ASSERT_NEVER(lbl, clk, rstn, cond) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) !(cond)) \
    else $error("i2cmis forbidden condition");
`else
`define I2CMIS_ASSERT(lbl, clk, rstn, prop)
`define I2CMIS_ASSERT_NEVER(lbl, clk, rstn, cond)
`endif
`endif

// ----- rtl/i2cmis_pkg.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// I2C master IRQ sequencer package
// Codes, slot numbering and the item record passed to the result queue.
// ----------------------------------------------------------------------------
package i2cmis_pkg;

  typedef enum logic [2:0] {
    KIND_TX       = 3'd0,
    KIND_RX       = 3'd1,
    KIND_EVENT    = 3'd2,
    KIND_ERROR    = 3'd3,
    KIND_SLAVE_EN = 3'd4
  } kind_e;

  typedef enum logic [3:0] {
    ACT_REPORT   = 4'd0,
    ACT_WRITE    = 4'd1,
    ACT_START    = 4'd2,
    ACT_STOP     = 4'd3,
    ACT_CLR_ADDR = 4'd4,
    ACT_SET_ACK  = 4'd5,
    ACT_DELIVER  = 4'd6,
    ACT_NOTIFY   = 4'd7,
    ACT_CLR_ERR  = 4'd8,
    ACT_CLR_STOP = 4'd9
  } action_e;

  typedef enum logic [3:0] {
    EV_TX_DONE   = 4'd0,
    EV_RX_DONE   = 4'd1,
    EV_STOP      = 4'd2,
    EV_DATA_REQ  = 4'd3,
    EV_DATA_RCVD = 4'd4,
    EV_ERR_BUS   = 4'd5
  } event_e;

  typedef enum logic [1:0] {
    MODE_READY   = 2'd0,
    MODE_BUSY_TX = 2'd1,
    MODE_BUSY_RX = 2'd2
  } mode_e;

  typedef enum logic [1:0] {
    CLS_BEGIN = 2'd0,
    CLS_EVENT = 2'd1,
    CLS_ERROR = 2'd2
  } cls_e;

  localparam int NUM_SLOTS = 16;
  localparam int SLOT_W    = 4;
  localparam int NUM_ERR   = 5;

  // begin request slots
  localparam int SLOT_REPORT = 0;
  localparam int SLOT_START  = 1;

  // event slots, in emission order
  localparam int SLOT_ADDR_BYTE = 0;
  localparam int SLOT_ADDR_NACK = 1;
  localparam int SLOT_CLR_ADDR  = 2;
  localparam int SLOT_TX_STOP   = 3;
  localparam int SLOT_TX_DONE   = 4;
  localparam int SLOT_CLR_STOP  = 5;
  localparam int SLOT_NOTE_STOP = 6;
  localparam int SLOT_TX_DATA   = 7;
  localparam int SLOT_DATA_REQ  = 8;
  localparam int SLOT_RX_NACK   = 9;
  localparam int SLOT_DELIVER   = 10;
  localparam int SLOT_RX_STOP   = 11;
  localparam int SLOT_RX_ACK    = 12;
  localparam int SLOT_RX_DONE   = 13;
  localparam int SLOT_DATA_RCVD = 14;

  // event flag bits
  localparam int EVB_START    = 0;
  localparam int EVB_ADDR     = 1;
  localparam int EVB_BTF      = 2;
  localparam int EVB_STOPF    = 3;
  localparam int EVB_TX_EMPTY = 4;
  localparam int EVB_RX_FULL  = 5;

  // interrupt enable bits
  localparam int IRQ_EVT = 0;
  localparam int IRQ_BUF = 1;
  localparam int IRQ_ERR = 2;

  typedef struct packed {
    cls_e                 cls;
    logic [NUM_SLOTS-1:0] mask;
    logic [1:0]           prior;
    logic [7:0]           addr_byte;
    logic [7:0]           tx_byte;
    logic [7:0]           rx_byte;
    logic [15:0]          idx;
  } res_t;

endpackage

// ----- rtl/i2cmis_apb.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// I2C master IRQ sequencer register port
// APB-style access to the ack_enable register.
// ----------------------------------------------------------------------------
module i2cmis_apb (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready,
  output logic        ack_enable_o
);

  localparam logic REG_ACK_ENABLE = 1'b0;

  logic ack_enable_q;
  logic ack_enable_d;
  logic wr_en;

  assign pready = 1'b1;
  assign wr_en  = psel & penable & pwrite & pready;

  always_comb begin
    ack_enable_d = ack_enable_q;
    if (wr_en && paddr[2] == REG_ACK_ENABLE) begin
      ack_enable_d = pwdata[0];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ack_enable_q <= 1'b1;
    end else begin
      ack_enable_q <= ack_enable_d;
    end
  end

  assign prdata       = (paddr[2] == REG_ACK_ENABLE) ? {31'd0, ack_enable_q} : 32'd0;
  assign ack_enable_o = ack_enable_q;

endmodule

// ----- rtl/i2cmis_core.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// I2C master IRQ sequencer core
// Input register, transfer state and the per-item action mask.
// ----------------------------------------------------------------------------
module i2cmis_core import i2cmis_pkg::*; #(
  parameter int LENGTH_BITS = 16
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_ready_o,
  input  logic [2:0]  kind_i,
  input  logic [15:0] length_i,
  input  logic [6:0]  target_addr_i,
  input  logic        keep_bus_i,
  input  logic        enable_i,
  input  logic [5:0]  event_flags_i,
  input  logic [4:0]  error_flags_i,
  input  logic        is_master_i,
  input  logic        is_transmitter_i,
  input  logic [7:0]  tx_byte_i,
  input  logic [7:0]  rx_byte_i,
  input  logic        ack_enable_i,
  input  logic        res_free_i,
  output logic        load_o,
  output res_t        res_o
);

  localparam int CW = LENGTH_BITS;

  logic        in_vld_q;
  logic [2:0]  in_kind_q;
  logic [15:0] in_len_q;
  logic [6:0]  in_addr_q;
  logic        in_keep_q;
  logic        in_en_q;
  logic [5:0]  in_ev_q;
  logic [4:0]  in_err_q;
  logic        in_master_q;
  logic        in_trans_q;
  logic [7:0]  in_tx_q;
  logic [7:0]  in_rx_q;

  mode_e        mode_q, mode_d;
  logic [CW-1:0] tx_rem_q, tx_rem_d;
  logic [CW-1:0] rx_rem_q, rx_rem_d;
  logic [CW-1:0] rx_total_q, rx_total_d;
  logic [6:0]   addr_q, addr_d;
  logic         hold_q, hold_d;
  logic         ack_bit_q, ack_bit_d;
  logic [2:0]   irq_en_q, irq_en_d;

  logic [CW-1:0] len;
  logic [CW-1:0] rx_left;
  logic          rx_ok;
  logic          tx_done;
  logic          take_in;

  assign load_o     = in_vld_q & res_free_i;
  assign in_ready_o = ~in_vld_q | load_o;
  assign take_in    = in_valid_i & in_ready_o;
  assign len        = CW'(in_len_q);

  always_comb begin
    mode_d     = mode_q;
    tx_rem_d   = tx_rem_q;
    rx_rem_d   = rx_rem_q;
    rx_total_d = rx_total_q;
    addr_d     = addr_q;
    hold_d     = hold_q;
    ack_bit_d  = ack_bit_q;
    irq_en_d   = irq_en_q;
    rx_ok      = 1'b0;
    rx_left    = rx_rem_q;
    tx_done    = 1'b0;

    res_o           = '0;
    res_o.cls       = CLS_BEGIN;
    res_o.prior     = mode_q;
    res_o.addr_byte = {addr_q, mode_q == MODE_BUSY_RX};
    res_o.tx_byte   = in_tx_q;
    res_o.rx_byte   = in_rx_q;
    res_o.idx       = 16'(rx_total_q - rx_rem_q);

    case (in_kind_q) inside
      KIND_TX, KIND_RX: begin
        res_o.mask[SLOT_REPORT] = 1'b1;
        if (mode_q != MODE_BUSY_TX && mode_q != MODE_BUSY_RX) begin
          res_o.mask[SLOT_START] = 1'b1;
          if (in_kind_q == KIND_RX) begin
            rx_rem_d   = len;
            rx_total_d = len;
            mode_d     = MODE_BUSY_RX;
          end else begin
            tx_rem_d = len;
            mode_d   = MODE_BUSY_TX;
          end
          addr_d   = in_addr_q;
          hold_d   = in_keep_q;
          irq_en_d = '1;
        end
      end
      KIND_EVENT: begin
        res_o.cls = CLS_EVENT;
        if (irq_en_q[IRQ_EVT]) begin
          if (in_ev_q[EVB_START] && (mode_q == MODE_BUSY_TX || mode_q == MODE_BUSY_RX)) begin
            res_o.mask[SLOT_ADDR_BYTE] = 1'b1;
          end
          if (in_ev_q[EVB_ADDR]) begin
            if (in_master_q && mode_q == MODE_BUSY_RX && rx_total_q == CW'(1)) begin
              res_o.mask[SLOT_ADDR_NACK] = 1'b1;
              ack_bit_d = 1'b0;
            end
            res_o.mask[SLOT_CLR_ADDR] = 1'b1;
          end
          tx_done = in_ev_q[EVB_BTF] && in_ev_q[EVB_TX_EMPTY] &&
                    mode_q == MODE_BUSY_TX && tx_rem_q == '0;
          if (tx_done) begin
            res_o.mask[SLOT_TX_STOP] = ~hold_q;
            res_o.mask[SLOT_TX_DONE] = 1'b1;
            irq_en_d[IRQ_EVT] = 1'b0;
            irq_en_d[IRQ_BUF] = 1'b0;
            mode_d   = MODE_READY;
            tx_rem_d = '0;
          end
          if (in_ev_q[EVB_STOPF]) begin
            res_o.mask[SLOT_CLR_STOP]  = 1'b1;
            res_o.mask[SLOT_NOTE_STOP] = 1'b1;
          end
          if (in_ev_q[EVB_TX_EMPTY] && irq_en_q[IRQ_BUF]) begin
            if (in_master_q) begin
              if (mode_q == MODE_BUSY_TX && tx_rem_q != '0) begin
                res_o.mask[SLOT_TX_DATA] = 1'b1;
                tx_rem_d = tx_rem_q - CW'(1);
              end
            end else if (in_trans_q) begin
              res_o.mask[SLOT_DATA_REQ] = 1'b1;
            end
          end
          if (in_ev_q[EVB_RX_FULL] && irq_en_q[IRQ_BUF]) begin
            if (in_master_q) begin
              if (mode_q == MODE_BUSY_RX) begin
                rx_ok = rx_total_q != '0 && rx_rem_q != '0;
                if (rx_ok) begin
                  if (rx_total_q > CW'(1) && rx_rem_q == CW'(2)) begin
                    res_o.mask[SLOT_RX_NACK] = 1'b1;
                    ack_bit_d = 1'b0;
                  end
                  res_o.mask[SLOT_DELIVER] = 1'b1;
                  rx_left = rx_rem_q - CW'(1);
                end
                rx_rem_d = rx_left;
                if (rx_left == '0) begin
                  res_o.mask[SLOT_RX_STOP] = ~hold_q;
                  irq_en_d[IRQ_EVT] = 1'b0;
                  irq_en_d[IRQ_BUF] = 1'b0;
                  mode_d     = MODE_READY;
                  rx_rem_d   = '0;
                  rx_total_d = '0;
                  if (ack_enable_i) begin
                    res_o.mask[SLOT_RX_ACK] = 1'b1;
                    ack_bit_d = 1'b1;
                  end
                  res_o.mask[SLOT_RX_DONE] = 1'b1;
                end
              end
            end else if (!in_trans_q) begin
              res_o.mask[SLOT_DATA_RCVD] = 1'b1;
            end
          end
        end
      end
      KIND_ERROR: begin
        res_o.cls = CLS_ERROR;
        if (irq_en_q[IRQ_ERR]) begin
          for (int i = 0; i < NUM_ERR; i++) begin
            res_o.mask[2*i]   = in_err_q[i];
            res_o.mask[2*i+1] = in_err_q[i];
          end
        end
      end
      KIND_SLAVE_EN: begin
        irq_en_d = in_en_q ? 3'b111 : 3'b000;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_vld_q   <= 1'b0;
      mode_q     <= MODE_READY;
      tx_rem_q   <= '0;
      rx_rem_q   <= '0;
      rx_total_q <= '0;
      addr_q     <= '0;
      hold_q     <= 1'b0;
      ack_bit_q  <= 1'b1;
      irq_en_q   <= '0;
    end else begin
      if (in_ready_o) begin
        in_vld_q <= in_valid_i;
      end
      if (load_o) begin
        mode_q     <= mode_d;
        tx_rem_q   <= tx_rem_d;
        rx_rem_q   <= rx_rem_d;
        rx_total_q <= rx_total_d;
        addr_q     <= addr_d;
        hold_q     <= hold_d;
        ack_bit_q  <= ack_bit_d;
        irq_en_q   <= irq_en_d;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (take_in) begin
      in_kind_q   <= kind_i;
      in_len_q    <= length_i;
      in_addr_q   <= target_addr_i;
      in_keep_q   <= keep_bus_i;
      in_en_q     <= enable_i;
      in_ev_q     <= event_flags_i;
      in_err_q    <= error_flags_i;
      in_master_q <= is_master_i;
      in_trans_q  <= is_transmitter_i;
      in_tx_q     <= tx_byte_i;
      in_rx_q     <= rx_byte_i;
    end
  end

endmodule

// ----- rtl/i2cmis_outq.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// I2C master IRQ sequencer result queue
// Holds one item's action mask and emits one action per cycle while out_ready_i is high, lowest slot first.
// ----------------------------------------------------------------------------
`include "i2c_master_irq_transfer_sequencer_unit_assert.svh"

module i2cmis_outq import i2cmis_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        load_i,
  input  res_t        res_i,
  output logic        res_free_o,
  output logic        out_valid_o,
  input  logic        out_ready_i,
  output logic [3:0]  action_o,
  output logic [7:0]  value_o,
  output logic [15:0] index_o,
  output logic [3:0]  event_code_o,
  output logic [1:0]  prior_state_o,
  output logic        last_o
);

  logic [NUM_SLOTS-1:0] mask_q, mask_d;
  res_t                 data_q;
  logic [NUM_SLOTS-1:0] onehot;
  logic [NUM_SLOTS-1:0] rest;
  logic [SLOT_W-1:0]    slot;
  logic                 take;
  action_e              act;
  logic [3:0]           code;

  assign onehot      = mask_q & (~mask_q + NUM_SLOTS'(1));
  assign rest        = mask_q & ~onehot;
  assign out_valid_o = |mask_q;
  assign last_o      = rest == '0;
  assign take        = out_valid_o & out_ready_i;
  assign res_free_o  = ~out_valid_o | (out_ready_i & last_o);

  always_comb begin
    slot = '0;
    for (int i = 0; i < NUM_SLOTS; i++) begin
      if (onehot[i]) begin
        slot = slot | SLOT_W'(i);
      end
    end
  end

  always_comb begin
    mask_d = mask_q;
    if (load_i) begin
      mask_d = res_i.mask;
    end else if (take) begin
      mask_d = rest;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mask_q <= '0;
    end else begin
      mask_q <= mask_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load_i) begin
      data_q <= res_i;
    end
  end

  always_comb begin
    act           = ACT_REPORT;
    value_o       = '0;
    index_o       = '0;
    code          = '0;
    prior_state_o = '0;
    unique case (data_q.cls)
      CLS_BEGIN: begin
        if (slot == SLOT_W'(SLOT_START)) begin
          act = ACT_START;
        end else begin
          prior_state_o = data_q.prior;
        end
      end
      CLS_EVENT: begin
        unique case (slot)
          SLOT_W'(SLOT_ADDR_BYTE): begin
            act     = ACT_WRITE;
            value_o = data_q.addr_byte;
          end
          SLOT_W'(SLOT_ADDR_NACK): act = ACT_SET_ACK;
          SLOT_W'(SLOT_CLR_ADDR):  act = ACT_CLR_ADDR;
          SLOT_W'(SLOT_TX_STOP):   act = ACT_STOP;
          SLOT_W'(SLOT_TX_DONE): begin
            act  = ACT_NOTIFY;
            code = EV_TX_DONE;
          end
          SLOT_W'(SLOT_CLR_STOP):  act = ACT_CLR_STOP;
          SLOT_W'(SLOT_NOTE_STOP): begin
            act  = ACT_NOTIFY;
            code = EV_STOP;
          end
          SLOT_W'(SLOT_TX_DATA): begin
            act     = ACT_WRITE;
            value_o = data_q.tx_byte;
          end
          SLOT_W'(SLOT_DATA_REQ): begin
            act  = ACT_NOTIFY;
            code = EV_DATA_REQ;
          end
          SLOT_W'(SLOT_RX_NACK):   act = ACT_SET_ACK;
          SLOT_W'(SLOT_DELIVER): begin
            act     = ACT_DELIVER;
            value_o = data_q.rx_byte;
            index_o = data_q.idx;
          end
          SLOT_W'(SLOT_RX_STOP):   act = ACT_STOP;
          SLOT_W'(SLOT_RX_ACK): begin
            act     = ACT_SET_ACK;
            value_o = 8'd1;
          end
          SLOT_W'(SLOT_RX_DONE): begin
            act  = ACT_NOTIFY;
            code = EV_RX_DONE;
          end
          SLOT_W'(SLOT_DATA_RCVD): begin
            act  = ACT_NOTIFY;
            code = EV_DATA_RCVD;
          end
          default: act = ACT_REPORT;
        endcase
      end
      CLS_ERROR: begin
        if (slot[0]) begin
          act  = ACT_NOTIFY;
          code = 4'(EV_ERR_BUS) + 4'(slot[SLOT_W-1:1]);
        end else begin
          act     = ACT_CLR_ERR;
          value_o = 8'(slot[SLOT_W-1:1]);
        end
      end
      default: ;
    endcase
  end

  assign action_o     = act;
  assign event_code_o = code;

  `I2CMIS_ASSERT(a_last_drains, clk_i, rst_ni, (take && last_o && !load_i) |=> !out_valid_o)
  `I2CMIS_ASSERT(a_one_per_take, clk_i, rst_ni, (take && !last_o && !load_i) |=> ($countones(mask_q) == $past($countones(mask_q)) - 1))
  `I2CMIS_ASSERT(a_load_when_free, clk_i, rst_ni, load_i |-> (!out_valid_o || (out_ready_i && last_o)))
  `I2CMIS_ASSERT_NEVER(a_begin_slots, clk_i, rst_ni, data_q.cls == CLS_BEGIN && (|mask_q[NUM_SLOTS-1:2]))

endmodule

// ----- rtl/i2c_master_irq_transfer_sequencer_unit.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// I2C master IRQ transfer sequencer
// Turns transfer requests and interrupt snapshots into ordered bus actions.
// ----------------------------------------------------------------------------
//  channel | handshake                | payload
//  --------+--------------------------+--------------------------------------
//  in      | in_valid_i / in_ready_o  | kind, length, address, flags, bytes
//  out     | out_valid_o / out_ready_i| action, value, index, code, prior, last
//  cfg     | psel/penable/pwrite/pready| paddr, pwdata, prdata
//
//  An item waits in the input register until the result queue is free, then its
//  actions are decoded into the queue in one pass; one action leaves per cycle
//  after that while out_ready_i is high. An item with no actions is decoded
//  without entering the queue. The queue's drain sets the rate.
//  The input register refills while the queue drains; stalls on out hold both.
//  Reset leaves the sequencer ready with interrupts off and ack_enable set.
// ----------------------------------------------------------------------------
module i2c_master_irq_transfer_sequencer_unit import i2cmis_pkg::*; #(
  parameter int LENGTH_BITS = 16
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_ready_o,
  input  logic [2:0]  kind_i,
  input  logic [15:0] length_i,
  input  logic [6:0]  target_addr_i,
  input  logic        keep_bus_i,
  input  logic        enable_i,
  input  logic [5:0]  event_flags_i,
  input  logic [4:0]  error_flags_i,
  input  logic        is_master_i,
  input  logic        is_transmitter_i,
  input  logic [7:0]  tx_byte_i,
  input  logic [7:0]  rx_byte_i,
  output logic        out_valid_o,
  input  logic        out_ready_i,
  output logic [3:0]  action_o,
  output logic [7:0]  value_o,
  output logic [15:0] index_o,
  output logic [3:0]  event_code_o,
  output logic [1:0]  prior_state_o,
  output logic        last_o,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);

  logic ack_enable;
  logic res_free;
  logic load;
  res_t res;

  i2cmis_apb u_apb (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .psel         (psel),
    .penable      (penable),
    .pwrite       (pwrite),
    .paddr        (paddr),
    .pwdata       (pwdata),
    .prdata       (prdata),
    .pready       (pready),
    .ack_enable_o (ack_enable)
  );

  i2cmis_core #(
    .LENGTH_BITS (LENGTH_BITS)
  ) u_core (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .in_valid_i       (in_valid_i),
    .in_ready_o       (in_ready_o),
    .kind_i           (kind_i),
    .length_i         (length_i),
    .target_addr_i    (target_addr_i),
    .keep_bus_i       (keep_bus_i),
    .enable_i         (enable_i),
    .event_flags_i    (event_flags_i),
    .error_flags_i    (error_flags_i),
    .is_master_i      (is_master_i),
    .is_transmitter_i (is_transmitter_i),
    .tx_byte_i        (tx_byte_i),
    .rx_byte_i        (rx_byte_i),
    .ack_enable_i     (ack_enable),
    .res_free_i       (res_free),
    .load_o           (load),
    .res_o            (res)
  );

  i2cmis_outq u_outq (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .load_i        (load),
    .res_i         (res),
    .res_free_o    (res_free),
    .out_valid_o   (out_valid_o),
    .out_ready_i   (out_ready_i),
    .action_o      (action_o),
    .value_o       (value_o),
    .index_o       (index_o),
    .event_code_o  (event_code_o),
    .prior_state_o (prior_state_o),
    .last_o        (last_o)
  );

endmodule
